### rtl/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared widths, defaults and controller/datapath interface types for the
// Taylor-series sine/cosine block.
// ----------------------------------------------------------------------------
package tsc_pkg;

    localparam int MAX_ITERATIONS_DEF = 16;
    localparam int FRACTION_BITS_DEF  = 28;

    localparam int ANGLE_W  = 32;
    localparam int VALUE_W  = 31;
    localparam int TERMS_W  = 5;
    localparam int THRESH_W = 29;
    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(268);

    // term magnitudes, running sum and multiplier operands
    localparam int MAG_W = 64;
    localparam logic [MAG_W-1:0] MAG_CAP = MAG_W'(1) << 61;

    // series denominators up to (2k)(2k+1) with k at most 32
    localparam int DIV_W = 13;

    typedef struct packed {
        logic load;
        logic mul_start;
        logic mul_term;
        logic x2_load;
        logic div_start;
        logic mag_load;
        logic accum;
        logic k_inc;
        logic out_load;
    } tsc_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic stop;
    } tsc_status_t;

endpackage

### rtl/tsc_mul.sv
// ----------------------------------------------------------------------------
// tsc_mul
// Sequential 64x64 multiplier on one 32x32 unit; returns the product shifted
// right by FRACTION_BITS and saturated to the magnitude cap.
// ----------------------------------------------------------------------------
module tsc_mul #(
    parameter int FRACTION_BITS = tsc_pkg::FRACTION_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [tsc_pkg::MAG_W-1:0]  op_a,
    input  logic [tsc_pkg::MAG_W-1:0]  op_b,
    output logic                       done,
    output logic [tsc_pkg::MAG_W-1:0]  result
);

    localparam int HALF_W = tsc_pkg::MAG_W / 2;
    localparam int PROD_W = 2 * tsc_pkg::MAG_W;
    localparam int PHASES = 4;

    logic [tsc_pkg::MAG_W-1:0] a_reg, b_reg;
    logic [PROD_W-1:0]         acc_reg;
    logic [2*HALF_W-1:0]       pp_reg;
    logic [1:0]                pp_idx_reg;
    logic [2:0]                phase_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic [HALF_W-1:0] a_chunk, b_chunk;
    logic [6:0]        sh_amt;
    logic [PROD_W-1:0] shifted;

    assign a_chunk = phase_reg[1] ? a_reg[tsc_pkg::MAG_W-1:HALF_W] : a_reg[HALF_W-1:0];
    assign b_chunk = phase_reg[0] ? b_reg[tsc_pkg::MAG_W-1:HALF_W] : b_reg[HALF_W-1:0];
    assign sh_amt  = {({1'b0, pp_idx_reg[1]} + {1'b0, pp_idx_reg[0]}), 5'd0};
    assign shifted = acc_reg >> FRACTION_BITS;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                a_reg     <= op_a;
                b_reg     <= op_b;
                acc_reg   <= '0;
                phase_reg <= '0;
                busy_reg  <= 1'b1;
            end else if (busy_reg) begin
                if (phase_reg < 3'(PHASES)) begin
                    pp_reg     <= a_chunk * b_chunk;
                    pp_idx_reg <= phase_reg[1:0];
                end
                if (phase_reg != 3'd0) begin
                    acc_reg <= acc_reg + (PROD_W'(pp_reg) << sh_amt);
                end
                if (phase_reg == 3'(PHASES)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                phase_reg <= phase_reg + 3'd1;
            end
        end
    end

    assign done   = done_reg;
    assign result = (shifted > PROD_W'(tsc_pkg::MAG_CAP)) ? tsc_pkg::MAG_CAP
                                                          : shifted[tsc_pkg::MAG_W-1:0];

endmodule

### rtl/tsc_div.sv
// ----------------------------------------------------------------------------
// tsc_div
// Iterative restoring divider, 64-bit dividend by a small unsigned divisor,
// four quotient bits per cycle, truncating.
// ----------------------------------------------------------------------------
module tsc_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [tsc_pkg::MAG_W-1:0]  dividend,
    input  logic [tsc_pkg::DIV_W-1:0]  divisor,
    output logic                       done,
    output logic [tsc_pkg::MAG_W-1:0]  quotient
);

    localparam int STEP_BITS = 4;
    localparam int CYCLES    = tsc_pkg::MAG_W / STEP_BITS;
    localparam int CNT_W     = $clog2(CYCLES);
    localparam int DW        = tsc_pkg::DIV_W;

    logic [tsc_pkg::MAG_W-1:0] q_reg;
    logic [DW-1:0]             rem_reg;
    logic [DW-1:0]             div_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic [tsc_pkg::MAG_W-1:0] q_next;
    logic [DW-1:0]             rem_next;

    always_comb begin
        logic [DW:0] trial;
        q_next   = q_reg;
        rem_next = rem_reg;
        for (int i = 0; i < STEP_BITS; i++) begin
            trial  = {rem_next, q_next[tsc_pkg::MAG_W-1]};
            q_next = {q_next[tsc_pkg::MAG_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg}) begin
                rem_next  = DW'(trial - {1'b0, div_reg});
                q_next[0] = 1'b1;
            end else begin
                rem_next = trial[DW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                q_reg    <= dividend;
                rem_reg  <= '0;
                div_reg  <= divisor;
                cnt_reg  <= CNT_W'(CYCLES - 1);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                q_reg   <= q_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

### rtl/tsc_datapath.sv
// ----------------------------------------------------------------------------
// tsc_datapath
// Operand, term and sum registers with the shared multiplier and the divider;
// executes the controller's commands and reports completion and stop.
// ----------------------------------------------------------------------------
module tsc_datapath #(
    parameter int MAX_ITERATIONS = tsc_pkg::MAX_ITERATIONS_DEF,
    parameter int FRACTION_BITS  = tsc_pkg::FRACTION_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tsc_pkg::tsc_cmd_t             cmd,
    output tsc_pkg::tsc_status_t          status,
    input  logic                          in_operation,
    input  logic [tsc_pkg::ANGLE_W-1:0]   in_angle,
    input  logic                          cfg_we,
    input  logic [tsc_pkg::THRESH_W-1:0]  cfg_wdata,
    output logic [tsc_pkg::VALUE_W-1:0]   out_value,
    output logic [tsc_pkg::TERMS_W-1:0]   out_terms_used
);

    localparam int MW  = tsc_pkg::MAG_W;
    localparam int AW  = tsc_pkg::ANGLE_W;
    localparam int DW  = tsc_pkg::DIV_W;
    localparam int K_W = $clog2(MAX_ITERATIONS + 1);
    localparam logic [MW-1:0]        ONE     = MW'(1) << FRACTION_BITS;
    localparam logic [MW-1:0]        LIM_RAW = MW'(2) << FRACTION_BITS;
    localparam logic [MW-1:0]        OUT_MAX = MW'(32'h3FFF_FFFF);
    localparam logic signed [MW-1:0] LIM     = (LIM_RAW > OUT_MAX) ? OUT_MAX : LIM_RAW;
    localparam logic signed [MW-1:0] CAP     = tsc_pkg::MAG_CAP;

    logic [tsc_pkg::THRESH_W-1:0] thresh_reg;
    logic                         cos_reg, neg_reg;
    logic [AW-1:0]                ax_reg;
    logic [MW-1:0]                x2_reg, mag_reg;
    logic signed [MW-1:0]         acc_reg;
    logic [K_W-1:0]               k_reg;
    logic [tsc_pkg::VALUE_W-1:0]  value_reg;
    logic [tsc_pkg::TERMS_W-1:0]  terms_reg;

    logic [AW-1:0]        ax_in;
    logic [MW-1:0]        mul_a, mul_b, mul_res, quo;
    logic                 mul_done, div_done;
    logic [DW-1:0]        two_k, denom;
    logic                 tneg;
    logic signed [MW-1:0] acc_sum, acc_next, value_sat;

    assign ax_in = in_angle[AW-1] ? (~in_angle + 1'b1) : in_angle;
    assign mul_a = cmd.mul_term ? mag_reg : MW'(ax_reg);
    assign mul_b = cmd.mul_term ? x2_reg  : MW'(ax_reg);

    assign two_k = DW'({k_reg, 1'b0});
    assign denom = cos_reg ? DW'(two_k * (two_k - 1'b1)) : DW'(two_k * (two_k + 1'b1));

    tsc_mul #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .result  (mul_res)
    );

    tsc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (mul_res),
        .divisor  (denom),
        .done     (div_done),
        .quotient (quo)
    );

    assign tneg    = k_reg[0] ^ (~cos_reg & neg_reg);
    assign acc_sum = tneg ? (acc_reg - $signed(mag_reg)) : (acc_reg + $signed(mag_reg));
    assign acc_next = (acc_sum > CAP) ? CAP : ((acc_sum < -CAP) ? -CAP : acc_sum);
    assign value_sat = (acc_reg > LIM) ? LIM : ((acc_reg < -LIM) ? -LIM : acc_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= tsc_pkg::THRESH_RESET;
        end else if (cfg_we) begin
            thresh_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cos_reg <= in_operation;
            neg_reg <= in_angle[AW-1];
            ax_reg  <= ax_in;
            mag_reg <= in_operation ? ONE : MW'(ax_in);
            acc_reg <= in_operation ? $signed(ONE) : MW'($signed(in_angle));
            k_reg   <= K_W'(1);
        end
        if (cmd.x2_load) begin
            x2_reg <= mul_res;
        end
        if (cmd.mag_load) begin
            mag_reg <= quo;
        end
        if (cmd.accum) begin
            acc_reg <= acc_next;
        end
        if (cmd.k_inc) begin
            k_reg <= k_reg + 1'b1;
        end
        if (cmd.out_load) begin
            value_reg <= value_sat[tsc_pkg::VALUE_W-1:0];
            terms_reg <= tsc_pkg::TERMS_W'(k_reg);
        end
    end

    assign status.mul_done = mul_done;
    assign status.div_done = div_done;
    assign status.stop     = (mag_reg <= MW'(thresh_reg)) ||
                             (k_reg == K_W'(MAX_ITERATIONS));

    assign out_value      = value_reg;
    assign out_terms_used = terms_reg;

endmodule

### rtl/tsc_ctrl.sv
// ----------------------------------------------------------------------------
// tsc_ctrl
// Sequencer: squares the angle, then per term runs multiply, divide and
// accumulate until the stop condition, then hands the result to the output.
// ----------------------------------------------------------------------------
module tsc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output tsc_pkg::tsc_cmd_t     cmd,
    input  tsc_pkg::tsc_status_t  status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_MUL,
        ST_SQ_WAIT,
        ST_T_MUL,
        ST_T_WAIT,
        ST_D_WAIT,
        ST_ACCUM,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd           = '0;
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SQ_MUL;
                end
            end
            ST_SQ_MUL: begin
                cmd.mul_start = 1'b1;
                state_next    = ST_SQ_WAIT;
            end
            ST_SQ_WAIT: begin
                if (status.mul_done) begin
                    cmd.x2_load = 1'b1;
                    state_next  = ST_T_MUL;
                end
            end
            ST_T_MUL: begin
                cmd.mul_start = 1'b1;
                cmd.mul_term  = 1'b1;
                state_next    = ST_T_WAIT;
            end
            ST_T_WAIT: begin
                if (status.mul_done) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_D_WAIT;
                end
            end
            ST_D_WAIT: begin
                if (status.div_done) begin
                    cmd.mag_load = 1'b1;
                    state_next   = ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                cmd.accum = 1'b1;
                if (status.stop) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.k_inc  = 1'b1;
                    state_next = ST_T_MUL;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

### rtl/taylor_sine_cosine.sv
// ----------------------------------------------------------------------------
// taylor_sine_cosine
// Fixed-point sine/cosine by Maclaurin series with a programmable stop level.
// ----------------------------------------------------------------------------
// Input stream: s_tdata carries the signed Q3.28 angle, s_tuser selects the
// function (0 sine, 1 cosine). One transaction is taken when the block is idle.
// Output stream: m_tdata carries the saturated Q2.28 value and the number of
// series terms added. Results leave through an output register, so the next
// angle is accepted while a result waits for m_tready.
// From accept to m_tvalid: the angle square, then per term a multiply on
// the shared 32x32 multiplier (four partial products), a divide on the
// 4-bit-per-cycle divider and an accumulate, then a load of the output
// register. A new angle is taken only after the last one has finished.
// cfg_we writes stop_threshold from cfg_wdata; write it only while idle.
// Reset (aresetn low, synchronous) empties the block and sets the threshold
// to 268. A stalled receiver holds m_tvalid and m_tdata; a finished result
// then waits in the sequencer until the output register frees.
// ----------------------------------------------------------------------------
module taylor_sine_cosine #(
    parameter int MAX_ITERATIONS = tsc_pkg::MAX_ITERATIONS_DEF,
    parameter int FRACTION_BITS  = tsc_pkg::FRACTION_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // [31:0] angle
    input  logic                          s_tuser,   // [0] operation
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [39:0]                   m_tdata,   // [30:0] value, [35:31] terms_used
    input  logic                          cfg_we,
    input  logic [tsc_pkg::THRESH_W-1:0]  cfg_wdata
);

    tsc_pkg::tsc_cmd_t    cmd;
    tsc_pkg::tsc_status_t status;

    logic [tsc_pkg::VALUE_W-1:0] value;
    logic [tsc_pkg::TERMS_W-1:0] terms_used;

    tsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    tsc_datapath #(
        .MAX_ITERATIONS (MAX_ITERATIONS),
        .FRACTION_BITS  (FRACTION_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .in_operation   (s_tuser),
        .in_angle       (s_tdata),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .out_value      (value),
        .out_terms_used (terms_used)
    );

    assign m_tdata = {4'd0, terms_used, value};

endmodule

### dv/tb_taylor_sine_cosine.sv
// ----------------------------------------------------------------------------
// tb_taylor_sine_cosine
// Self-checking testbench for the Taylor-series sine/cosine block. Each
// accepted angle is run through a bit-exact series model, and the expected
// value and term count are queued. Every output transaction is checked in
// order. Stimulus covers directed edge angles, stop-threshold extremes,
// random thresholds and angles with random idling on both streams, a long
// output stall and a final phase at full rate.
// ----------------------------------------------------------------------------
module tb_taylor_sine_cosine;

    localparam int FRAC  = tsc_pkg::FRACTION_BITS_DEF;
    localparam int ITERS = tsc_pkg::MAX_ITERATIONS_DEF;
    localparam logic [tsc_pkg::THRESH_W-1:0] THRESH_MAX = '1;

    localparam logic OP_SINE   = 1'b0;
    localparam logic OP_COSINE = 1'b1;

    typedef struct packed {
        logic [tsc_pkg::VALUE_W-1:0] value;
        logic [tsc_pkg::TERMS_W-1:0] terms;
    } series_result_t;

    logic                         aclk;
    logic                         aresetn;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [31:0]                  s_tdata;   // [31:0] angle
    logic                         s_tuser;   // [0] operation
    logic                         m_tvalid;
    logic                         m_tready;
    logic [39:0]                  m_tdata;   // [30:0] value, [35:31] terms_used
    logic                         cfg_we;
    logic [tsc_pkg::THRESH_W-1:0] cfg_wdata;

    logic [tsc_pkg::THRESH_W-1:0] threshold_cfg;
    series_result_t               series_due[$];
    int                           errors;
    bit                           src_gaps;
    bit                           sink_gaps;
    int                           stall_cycles;

    taylor_sine_cosine u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // (a*b) >> FRAC, saturated to the magnitude cap
    function automatic logic [63:0] scaled_product(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p >> FRAC;
        if (p > {64'd0, tsc_pkg::MAG_CAP})
            return tsc_pkg::MAG_CAP;
        return p[63:0];
    endfunction

    function automatic series_result_t sine_cosine_series(input logic cosine,
                                                          input logic [31:0] angle,
                                                          input logic [tsc_pkg::THRESH_W-1:0] thr);
        logic                neg;
        logic                tneg;
        logic [63:0]         ax;
        logic [63:0]         x2;
        logic [63:0]         mag;
        logic [63:0]         den;
        logic signed [63:0]  acc;
        logic signed [63:0]  cap;
        logic signed [63:0]  lim;
        int                  used;
        series_result_t      r;
        neg = angle[31];
        ax  = neg ? (64'd1 << 32) - {32'd0, angle} : {32'd0, angle};
        x2  = scaled_product(ax, ax);
        cap = $signed(tsc_pkg::MAG_CAP);
        if (cosine) begin
            mag = 64'd1 << FRAC;
            acc = $signed(mag);
        end else begin
            mag = ax;
            acc = {{32{angle[31]}}, angle};
        end
        used = 0;
        for (int k = 1; k <= ITERS; k++) begin
            den  = cosine ? 64'((2 * k - 1) * (2 * k)) : 64'((2 * k) * (2 * k + 1));
            tneg = (k % 2 == 1) ^ (!cosine && neg);
            mag  = scaled_product(mag, x2) / den;
            acc  = tneg ? acc - $signed(mag) : acc + $signed(mag);
            if (acc > cap)
                acc = cap;
            if (acc < -cap)
                acc = -cap;
            used++;
            if (mag <= {35'd0, thr})
                break;
        end
        lim = 64'sd2 <<< FRAC;
        if (lim > 64'sh3FFF_FFFF)
            lim = 64'sh3FFF_FFFF;
        if (acc > lim)
            acc = lim;
        if (acc < -lim)
            acc = -lim;
        r.value = acc[tsc_pkg::VALUE_W-1:0];
        r.terms = used[tsc_pkg::TERMS_W-1:0];
        return r;
    endfunction

    task automatic offer_angle(input logic op, input logic [31:0] angle);
        int n;
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= angle;
        s_tuser  <= op;
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        series_due.push_back(sine_cosine_series(op, angle, threshold_cfg));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (series_due.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [tsc_pkg::THRESH_W-1:0] thr);
        cfg_we    <= 1'b1;
        cfg_wdata <= thr;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        threshold_cfg = thr;
    endtask

    function automatic logic [31:0] pick_angle();
        logic [31:0] r;
        case ($urandom_range(0, 7))
            0: r = $urandom;
            1: begin
                r = $urandom_range(0, 32'h0010_0000);
                if ($urandom_range(0, 1) == 1)
                    r = -r;
            end
            default: r = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
        endcase
        return r;
    endfunction

    function automatic logic [tsc_pkg::THRESH_W-1:0] pick_threshold();
        case ($urandom_range(0, 2))
            0: return tsc_pkg::THRESH_W'($urandom_range(1, 1023));
            1: return tsc_pkg::THRESH_W'($urandom_range(1, 32'h0010_0000));
            default: return tsc_pkg::THRESH_W'($urandom);
        endcase
    endfunction

    task automatic random_burst(input int count);
        repeat (count) offer_angle(1'($urandom_range(0, 1)), pick_angle());
    endtask

    task automatic test_directed_angles();
        logic [31:0] angles[8];
        angles = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h1000_0000,
                   32'h1921_FB54, 32'h3243_F6A9, 32'h4000_0000, 32'hC000_0000};
        foreach (angles[i]) begin
            offer_angle(OP_SINE, angles[i]);
            offer_angle(OP_COSINE, angles[i]);
        end
        drain_results();
        // zero threshold with angles near +/-8: runs to the iteration limit
        write_threshold('0);
        offer_angle(OP_SINE, 32'h7FFF_FFFF);
        offer_angle(OP_COSINE, 32'h7FFF_FFFF);
        offer_angle(OP_SINE, 32'h8000_0000);
        offer_angle(OP_COSINE, 32'h8000_0000);
        drain_results();
        write_threshold(THRESH_MAX);
        offer_angle(OP_SINE, 32'h1000_0000);
        offer_angle(OP_COSINE, 32'hC000_0000);
        drain_results();
    endtask

    task automatic test_threshold_extremes();
        logic [tsc_pkg::THRESH_W-1:0] levels[4];
        levels = '{29'd1, 29'h1000_0000, THRESH_MAX, 29'd0};
        foreach (levels[i]) begin
            write_threshold(levels[i]);
            random_burst(40);
            drain_results();
        end
    endtask

    task automatic test_random_thresholds();
        repeat (10) begin
            write_threshold(pick_threshold());
            random_burst(50);
            drain_results();
        end
    endtask

    task automatic test_output_stall();
        write_threshold(tsc_pkg::THRESH_RESET);
        src_gaps     = 0;
        stall_cycles = 3000;
        random_burst(12);
        drain_results();
        src_gaps = 1;
    endtask

    task automatic test_full_rate();
        src_gaps  = 0;
        sink_gaps = 0;
        random_burst(90);
        drain_results();
        write_threshold(pick_threshold());
        random_burst(90);
        drain_results();
    endtask

    initial begin : result_sink
        int n;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_cycles > 0) begin
                m_tready <= 1'b0;
                while (stall_cycles > 0) begin
                    @(posedge aclk);
                    stall_cycles--;
                end
            end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 8);
                m_tready <= 1'b0;
                repeat (n - 1) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : result_check
        series_result_t want;
        forever begin
            @(negedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (series_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected transaction value=%0d terms=%0d", $time,
                             $signed(m_tdata[30:0]), m_tdata[35:31]);
                end else begin
                    want = series_due.pop_front();
                    if (m_tdata[30:0] !== want.value) begin
                        errors++;
                        $display("%0t: value expected %0d actual %0d", $time,
                                 $signed(want.value), $signed(m_tdata[30:0]));
                    end
                    if (m_tdata[35:31] !== want.terms) begin
                        errors++;
                        $display("%0t: terms_used expected %0d actual %0d", $time,
                                 want.terms, m_tdata[35:31]);
                    end
                end
            end
        end
    end

    initial begin
        #20000000;
        $display("taylor_sine_cosine regression: fail");
        $finish;
    end

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        threshold_cfg = tsc_pkg::THRESH_RESET;
        errors        = 0;
        src_gaps      = 1;
        sink_gaps     = 1;
        stall_cycles  = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_angles();
        test_threshold_extremes();
        test_random_thresholds();
        test_output_stall();
        test_full_rate();

        drain_results();
        repeat (450) @(posedge aclk);
        if (series_due.size() != 0) begin
            errors++;
            $display("%0t: %0d transactions never arrived", $time, series_due.size());
        end
        if (errors == 0) begin
            $display("taylor_sine_cosine regression: pass");
        end else begin
            $display("taylor_sine_cosine regression: fail");
        end
        $finish;
    end

endmodule
